// ===== sv/sdcp_pkg.sv =====
// Shared types, codes and constants for the serial display command parser.
package sdcp_pkg;

    // Frame size in bytes; the cursor wraps to 0 at this value
    localparam logic [15:0] FRAME_BYTES = 16'd384;
    localparam int          ADDR_W      = 9;

    // Attention codes (unquoted bytes below 4)
    localparam logic [7:0] ATN_LEFT  = 8'd0;
    localparam logic [7:0] ATN_RIGHT = 8'd1;
    localparam logic [7:0] ATN_BOTH  = 8'd2;
    localparam logic [7:0] ATN_QUOTE = 8'd3;
    localparam logic [7:0] ATN_LIMIT = 8'd4;

    // Command bytes
    localparam logic [7:0] CMD_RANDOM_LIFE   = 8'd64;
    localparam logic [7:0] CMD_EXPLICIT_LIFE = 8'd65;
    localparam logic [7:0] CMD_TEST_PATTERN  = 8'd66;
    localparam logic [7:0] CMD_HOLD_SINGLE   = 8'd67;
    localparam logic [7:0] CMD_HOLD_DOUBLE   = 8'd68;
    localparam logic [7:0] CMD_CLEAR         = 8'd70;
    localparam logic [7:0] CMD_SET_X         = 8'd71;
    localparam logic [7:0] CMD_SET_Y         = 8'd72;
    localparam logic [7:0] CMD_SWAP          = 8'd73;
    localparam logic [7:0] CMD_LIFE_STEP     = 8'd74;

    // Argument bytes are biased by this amount
    localparam logic [15:0] ARG_BIAS = 16'd128;

    typedef enum logic [2:0] {
        ACT_NONE   = 3'd0,
        ACT_WRITE  = 3'd1,
        ACT_CLEAR  = 3'd2,
        ACT_LIFE   = 3'd3,
        ACT_RANDOM = 3'd4,
        ACT_SWAP   = 3'd5
    } action_t;

    typedef enum logic [2:0] {
        MODE_RANDOM_LIFE   = 3'd0,
        MODE_EXPLICIT_LIFE = 3'd1,
        MODE_TEST_PATTERN  = 3'd2,
        MODE_HOLD_SINGLE   = 3'd3,
        MODE_HOLD_DOUBLE   = 3'd4
    } mode_t;

    // Parser state carried from item to item
    typedef struct packed {
        logic        addressed;
        logic        quote_pending;
        logic        expect_command;
        logic        expect_argument;
        logic        argument_is_y;
        logic [15:0] cursor;
        mode_t       mode;
        logic        write_to_shown;
        logic        shown_select;
    } parse_state_t;

    // One result item
    typedef struct packed {
        action_t             action;
        logic                target_buffer;
        logic [ADDR_W-1:0]   write_address;
        logic [7:0]          write_data;
        mode_t               run_mode;
        logic                show_buffer;
    } result_t;

endpackage

// ===== sv/sdcp_decode.sv =====
// Next-state and result logic for one received item.
module sdcp_decode
    import sdcp_pkg::*;
(
    input  parse_state_t cur,
    input  logic         kind,
    input  logic [7:0]   rx_byte,
    input  logic         left_half,
    output parse_state_t nxt,
    output result_t      res
);

    logic [15:0] arg_val;
    logic [15:0] wr_cursor;
    logic [7:0]  own_code;
    logic        wr_target;

    assign arg_val   = {8'd0, rx_byte} - ARG_BIAS;
    assign wr_cursor = (cur.cursor >= FRAME_BYTES) ? 16'd0 : cur.cursor;
    assign own_code  = left_half ? ATN_LEFT : ATN_RIGHT;
    assign wr_target = cur.write_to_shown ? cur.shown_select : ~cur.shown_select;

    // Decode of one item
    always_comb begin
        action_t           act;
        logic              tgt;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;

        nxt  = cur;
        act  = ACT_NONE;
        tgt  = 1'b0;
        addr = '0;
        data = '0;

        if (kind) begin
            // external swap notice from the main loop
            nxt.shown_select = ~cur.shown_select;
        end else if (!cur.quote_pending && rx_byte < ATN_LIMIT) begin
            // attention code
            if (rx_byte == ATN_QUOTE) begin
                nxt.quote_pending = 1'b1;
            end else if (rx_byte == ATN_BOTH || rx_byte == own_code) begin
                nxt.addressed      = 1'b1;
                nxt.expect_command = 1'b1;
            end else begin
                nxt.addressed      = 1'b0;
                nxt.expect_command = 1'b0;
            end
        end else begin
            nxt.quote_pending = 1'b0;
            if (cur.addressed) begin
                if (cur.expect_command) begin
                    nxt.expect_command = 1'b0;
                    if (!cur.expect_argument) begin
                        case (rx_byte)
                            CMD_RANDOM_LIFE: begin
                                nxt.mode = MODE_RANDOM_LIFE;
                                act      = ACT_RANDOM;
                                tgt      = ~cur.shown_select;
                            end
                            CMD_EXPLICIT_LIFE: begin
                                nxt.mode = MODE_EXPLICIT_LIFE;
                            end
                            CMD_TEST_PATTERN: begin
                                nxt.mode = MODE_TEST_PATTERN;
                            end
                            CMD_HOLD_SINGLE: begin
                                nxt.mode           = MODE_HOLD_SINGLE;
                                nxt.write_to_shown = 1'b1;
                            end
                            CMD_HOLD_DOUBLE: begin
                                nxt.mode           = MODE_HOLD_DOUBLE;
                                nxt.write_to_shown = 1'b0;
                            end
                            CMD_CLEAR: begin
                                act        = ACT_CLEAR;
                                tgt        = wr_target;
                                nxt.cursor = '0;
                            end
                            CMD_SET_X, CMD_SET_Y: begin
                                nxt.expect_command  = 1'b1;
                                nxt.expect_argument = 1'b1;
                                nxt.argument_is_y   = (rx_byte == CMD_SET_Y);
                            end
                            CMD_SWAP: begin
                                nxt.shown_select = ~cur.shown_select;
                                act              = ACT_SWAP;
                                tgt              = ~cur.shown_select;
                            end
                            CMD_LIFE_STEP: begin
                                act              = ACT_LIFE;
                                tgt              = ~cur.shown_select;
                                nxt.shown_select = ~cur.shown_select;
                            end
                            default: begin
                                // unknown command: ignored
                            end
                        endcase
                    end else begin
                        // argument byte for a cursor command
                        nxt.expect_argument = 1'b0;
                        if (cur.argument_is_y) begin
                            nxt.cursor = {arg_val[12:0], cur.cursor[2:0]};
                        end else begin
                            nxt.cursor = arg_val + {cur.cursor[15:3], 3'b000};
                        end
                    end
                end else begin
                    // frame data written at the cursor
                    act        = ACT_WRITE;
                    tgt        = wr_target;
                    addr       = wr_cursor[ADDR_W-1:0];
                    data       = rx_byte;
                    nxt.cursor = wr_cursor + 16'd1;
                end
            end
        end

        res.action        = act;
        res.target_buffer = tgt;
        res.write_address = addr;
        res.write_data    = data;
        res.run_mode      = nxt.mode;
        res.show_buffer   = nxt.shown_select;
    end

endmodule

// ===== sv/sdcp_out.sv =====
// Result register with a skid entry so input can flow while the output stalls.
module sdcp_out
    import sdcp_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    in_valid,
    output logic    in_ready,
    input  result_t in_res,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_res
);

    logic    main_valid_reg;
    logic    skid_valid_reg;
    result_t main_reg;
    result_t skid_reg;
    logic    pop;
    logic    push;

    assign in_ready  = ~skid_valid_reg;
    assign pop       = main_valid_reg & out_ready;
    assign push      = in_valid & in_ready;
    assign out_valid = main_valid_reg;
    assign out_res   = main_reg;

    // Control flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (pop) begin
                skid_valid_reg <= 1'b0;
            end
        end else if (!main_valid_reg || pop) begin
            main_valid_reg <= push;
        end else if (push) begin
            skid_valid_reg <= 1'b1;
        end
    end

    // Payload
    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (pop) begin
                main_reg <= skid_reg;
            end
        end else if (!main_valid_reg || pop) begin
            main_reg <= in_res;
        end else if (push) begin
            skid_reg <= in_res;
        end
    end

endmodule

// ===== sv/serial_display_command_parser_unit.sv =====
// Top level of the serial display command parser.
//
// Takes one item per clock while s_tready is high: a received serial byte
// (s_tuser = 0) or a notice that the main loop swapped the frame buffers
// (s_tuser = 1). Each item yields exactly one result, presented on the
// cycle after it is accepted unless earlier results are still waiting,
// carrying the action (m_tuser), its target buffer, write address and data,
// the run mode and the buffer on display. The parser state updates in the
// accepting cycle, so a new item can be taken every clock; a two-entry output
// stage lets input flow while m_tready is low; input stalls only once both
// entries hold results. The user writes left_half through cfg_wr_en/cfg_wr_data
// only while the block is idle; the block itself does not enforce this.
module serial_display_command_parser_unit
    import sdcp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,    // left_half
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,        // [7:0] rx_byte
    input  logic        s_tuser,        // [0] kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,        // [0] target_buffer, [9:1] write_address,
                                        // [17:10] write_data, [20:18] run_mode,
                                        // [21] show_buffer, [23:22] zero
    output logic [2:0]  m_tuser         // [2:0] action
);

    parse_state_t state_reg;
    parse_state_t state_next;
    logic         left_half_reg;
    result_t      dec_res;
    result_t      out_res;
    logic         accept;

    assign accept = s_tvalid & s_tready;

    // Configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_half_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            left_half_reg <= cfg_wr_data;
        end
    end

    // Parser state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '{
                addressed:       1'b0,
                quote_pending:   1'b0,
                expect_command:  1'b0,
                expect_argument: 1'b0,
                argument_is_y:   1'b0,
                cursor:          16'd0,
                mode:            MODE_RANDOM_LIFE,
                write_to_shown:  1'b0,
                shown_select:    1'b0
            };
        end else if (accept) begin
            state_reg <= state_next;
        end
    end

    sdcp_decode u_decode (
        .cur       (state_reg),
        .kind      (s_tuser),
        .rx_byte   (s_tdata),
        .left_half (left_half_reg),
        .nxt       (state_next),
        .res       (dec_res)
    );

    sdcp_out u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_res    (dec_res),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (out_res)
    );

    // Result packing
    assign m_tuser = out_res.action;
    assign m_tdata = {2'b00, out_res.show_buffer, out_res.run_mode, out_res.write_data,
                      out_res.write_address, out_res.target_buffer};

endmodule
